// ===== src/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce press classifier package
// Shared types and constants for the debouncer and its press phase machine.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 8;

  localparam logic [ThreshW-1:0] DebounceMsRst  = 16'd10;
  localparam logic [ThreshW-1:0] LongPressMsRst = 16'd1000;

  // Register index, taken from paddr[2].
  localparam logic RegDebounce  = 1'b0;
  localparam logic RegLongPress = 1'b1;

  typedef enum logic [4:0] {
    PhaseIdle    = 5'b00001,
    PhaseBounce  = 5'b00010,
    PhasePressed = 5'b00100,
    PhaseLong    = 5'b01000,
    PhaseRelease = 5'b10000
  } phase_e;

  typedef enum logic [ClassW-1:0] {
    ClassNone  = 2'd0,
    ClassShort = 2'd1,
    ClassLong  = 2'd2
  } press_class_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             raw_level;
  } sample_t;

  typedef struct packed {
    logic [ThreshW-1:0] debounce_ms;
    logic [ThreshW-1:0] long_press_ms;
  } cfg_t;

endpackage

// ===== src/bdpc_fsm.sv =====
// ----------------------------------------------------------------------------
// Press phase machine
// Holds the debounce phase and timestamps, and classifies one sample per step.
// ----------------------------------------------------------------------------
module bdpc_fsm import bdpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  sample_t      sample_i,
  input  cfg_t         cfg_i,
  output press_class_e class_o,
  output phase_e       phase_o
);

  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   last_change_q, last_change_d;
  logic [TimeW-1:0]   stable_press_q, stable_press_d;
  logic [TimeW-1:0]   since_change;
  logic [TimeW-1:0]   since_stable;
  logic               down;
  logic               debounced;
  logic               is_long;

  assign down         = ~sample_i.raw_level;
  assign since_change = sample_i.now_ms - last_change_q;
  assign since_stable = sample_i.now_ms - stable_press_q;
  assign debounced    = since_change >= {{(TimeW-ThreshW){1'b0}}, cfg_i.debounce_ms};
  assign is_long      = since_stable >= {{(TimeW-ThreshW){1'b0}}, cfg_i.long_press_ms};

  always_comb begin
    phase_d        = phase_q;
    last_change_d  = last_change_q;
    stable_press_d = stable_press_q;
    class_o        = ClassNone;
    unique case (phase_q)
      PhaseBounce: begin
        if (down) begin
          if (debounced) begin
            phase_d        = PhasePressed;
            stable_press_d = sample_i.now_ms;
          end
        end else begin
          last_change_d = sample_i.now_ms;
          phase_d       = PhaseIdle;
        end
      end
      PhasePressed: begin
        if (down) begin
          if (is_long) begin
            phase_d = PhaseLong;
          end
        end else begin
          last_change_d = sample_i.now_ms;
          phase_d       = PhaseRelease;
        end
      end
      PhaseLong: begin
        if (!down) begin
          last_change_d = sample_i.now_ms;
          phase_d       = PhaseRelease;
        end
      end
      PhaseRelease: begin
        // A press seen while the release settles is contact bounce.
        if (down) begin
          phase_d       = is_long ? PhaseLong : PhasePressed;
          last_change_d = sample_i.now_ms;
        end else if (debounced) begin
          phase_d = PhaseIdle;
          class_o = is_long ? ClassLong : ClassShort;
        end
      end
      default: begin
        if (down) begin
          phase_d       = PhaseBounce;
          last_change_d = sample_i.now_ms;
        end else begin
          phase_d = PhaseIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhaseIdle;
      last_change_q  <= '0;
      stable_press_q <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      last_change_q  <= last_change_d;
      stable_press_q <= stable_press_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// ===== src/button_debounce_press_classifier.sv =====
// Each sample is held in the input register, and its press class in the output register.
// Throughput: one sample per cycle; the phase machine steps once per item.
// A stalled result holds the machine, and new samples stop once the input
// register is full as well.
// Reset (rst_ni low, asynchronous): phase goes idle, timestamps clear,
// debounce_ms returns to 10 and long_press_ms to 1000.
// ----------------------------------------------------------------------------
// Button debounce press classifier
// Debounces an active-low button and reports short and long presses.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier import bdpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready,
  // Sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // [0] raw_level, [32:1] now_ms
  // Press class stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata   // [1:0] press_class
);

  cfg_t         cfg_q;
  sample_t      in_q;
  logic         in_vld_q;
  press_class_e out_cls_q;
  logic         out_vld_q;
  logic         advance;
  logic         cfg_wr;
  press_class_e step_cls;
  phase_e       phase;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceMsRst;
      cfg_q.long_press_ms <= LongPressMsRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDebounce) begin
        cfg_q.debounce_ms <= pwdata[ThreshW-1:0];
      end else begin
        cfg_q.long_press_ms <= pwdata[ThreshW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegLongPress) begin
      prdata[ThreshW-1:0] = cfg_q.long_press_ms;
    end else begin
      prdata[ThreshW-1:0] = cfg_q.debounce_ms;
    end
  end

  // The sample in the input register steps the machine when the output
  // register is free or being drained.
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.raw_level <= s_axis_tdata[0];
      in_q.now_ms    <= s_axis_tdata[TimeW:1];
    end
  end

  bdpc_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_q),
    .cfg_i    (cfg_q),
    .class_o  (step_cls),
    .phase_o  (phase)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (~out_vld_q | m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_cls_q <= step_cls;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW-ClassW){1'b0}}, out_cls_q};

`ifndef SYNTHESIS
  // A completed press always leaves the machine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_cls != ClassNone |=> phase == PhaseIdle)
    else $error("press reported without return to idle");

  // A press is only reported out of the release phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_cls != ClassNone |-> phase == PhaseRelease)
    else $error("press reported outside release phase");

  // A sample stuck behind a full output is held, not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_q))
    else $error("stalled sample lost");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Button debounce press classifier testbench
// Streams button samples with bouncy presses of chosen lengths and random
// noise through the classifier. A local copy of the phase machine predicts
// the press class for each item, and the results are checked in order.
// Thresholds are reprogrammed over APB between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
  import bdpc_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseCount = 6;
  localparam int unsigned PhaseItems = 230;
  localparam logic [AddrW-1:0] DebounceAddr  = {RegDebounce, 2'b00};
  localparam logic [AddrW-1:0] LongPressAddr = {RegLongPress, 2'b00};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrW-1:0]     paddr   = '0;
  logic [DataW-1:0]     pwdata  = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // [0] raw_level, [32:1] now_ms
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // [1:0] press_class

  button_debounce_press_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Pending samples and the press classes they are expected to produce.
  sample_t      sample_q[$];
  press_class_e expected_class_q[$];
  int unsigned  n_queued   = 0;
  int unsigned  n_accepted = 0;
  int unsigned  err_cnt    = 0;
  int unsigned  cycles     = 0;
  logic         sample_took = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  // Local copy of the phase machine and its thresholds.
  phase_e             btn_phase        = PhaseIdle;
  logic [TimeW-1:0]   last_edge_ms     = '0;
  logic [TimeW-1:0]   press_start_ms   = '0;
  logic [ThreshW-1:0] debounce_ms_q    = DebounceMsRst;
  logic [ThreshW-1:0] long_press_ms_q  = LongPressMsRst;

  // Thresholds the stimulus is shaped around, and the running timestamp.
  int unsigned      deb_t   = DebounceMsRst;
  int unsigned      long_t  = LongPressMsRst;
  logic [TimeW-1:0] now_cur = '0;

  int unsigned deb_set  [PhaseCount] = '{10, 0, 65535, 3, 0, 25};
  int unsigned long_set [PhaseCount] = '{1000, 0, 65535, 40, 300, 0};

  function automatic press_class_e classify_sample(logic raw, logic [TimeW-1:0] now);
    logic             down;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] since_press;
    press_class_e     cls;
    down        = !raw;
    since_edge  = now - last_edge_ms;
    since_press = now - press_start_ms;
    cls         = ClassNone;
    case (btn_phase)
      PhaseBounce: begin
        if (down) begin
          if (since_edge >= debounce_ms_q) begin
            btn_phase      = PhasePressed;
            press_start_ms = now;
          end
        end else begin
          last_edge_ms = now;
          btn_phase    = PhaseIdle;
        end
      end
      PhasePressed: begin
        if (down) begin
          if (since_press >= long_press_ms_q) btn_phase = PhaseLong;
        end else begin
          last_edge_ms = now;
          btn_phase    = PhaseRelease;
        end
      end
      PhaseLong: begin
        if (!down) begin
          last_edge_ms = now;
          btn_phase    = PhaseRelease;
        end
      end
      PhaseRelease: begin
        // A press while the release settles resumes the held press.
        if (down) begin
          btn_phase    = (since_press < long_press_ms_q) ? PhasePressed : PhaseLong;
          last_edge_ms = now;
        end else if (since_edge >= debounce_ms_q) begin
          btn_phase = PhaseIdle;
          cls       = (since_press < long_press_ms_q) ? ClassShort : ClassLong;
        end
      end
      default: begin
        if (down) begin
          btn_phase    = PhaseBounce;
          last_edge_ms = now;
        end else begin
          btn_phase = PhaseIdle;
        end
      end
    endcase
    return cls;
  endfunction

  // Sample driver.
  always @(negedge clk_i) begin : drive_samples
    sample_t item;
    if (!s_axis_tvalid || sample_took) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item = sample_q.pop_front();
        s_axis_tdata  <= InTdataW'(item);
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predicts on accepted samples, checks accepted classes.
  always @(posedge clk_i) begin : watch_stream
    sample_t      got;
    press_class_e want;
    cycles++;
    sample_took <= s_axis_tvalid && s_axis_tready;
    if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegDebounce) debounce_ms_q = pwdata[ThreshW-1:0];
      else long_press_ms_q = pwdata[ThreshW-1:0];
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      got = sample_t'(s_axis_tdata[$bits(sample_t)-1:0]);
      expected_class_q.push_back(classify_sample(got.raw_level, got.now_ms));
      n_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_class_q.size() == 0) begin
        $error("unexpected press_class item, actual %0d", m_axis_tdata[ClassW-1:0]);
        err_cnt++;
      end else begin
        want = expected_class_q.pop_front();
        if (m_axis_tdata[ClassW-1:0] !== want) begin
          $error("press_class expected %0d actual %0d", want, m_axis_tdata[ClassW-1:0]);
          err_cnt++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_sample(logic level, logic [TimeW-1:0] t);
    sample_t item;
    now_cur         = t;
    item.raw_level  = level;
    item.now_ms     = t;
    sample_q.push_back(item);
    n_queued++;
  endtask

  task automatic add_sample(logic level, int unsigned dt);
    push_sample(level, now_cur + TimeW'(dt));
  endtask

  // Holds a level for about dur ms, spread over a few samples.
  task automatic add_hold(logic level, int unsigned dur);
    int unsigned k;
    int unsigned part;
    k    = $urandom_range(1, 4);
    part = dur / k;
    for (int unsigned i = 1; i < k; i++) add_sample(level, part);
    add_sample(level, dur - (k - 1) * part);
  endtask

  function automatic int unsigned near(int unsigned thr);
    int unsigned off;
    off = $urandom_range(0, 4);
    return (thr + off < 2) ? 0 : thr + off - 2;
  endfunction

  // One press with up to two contact bounces on each edge and a length picked
  // around, below or above the long-press threshold.
  task automatic add_press();
    int unsigned hold;
    add_sample(1'b1, $urandom_range(1, 50));
    repeat ($urandom_range(0, 2)) begin
      add_sample(1'b0, $urandom_range(0, deb_t / 2));
      add_sample(1'b1, $urandom_range(0, deb_t / 2));
    end
    add_sample(1'b0, $urandom_range(1, 20));
    add_hold(1'b0, near(deb_t));
    case ($urandom_range(0, 2))
      0: hold = near(long_t);
      1: hold = $urandom_range(0, long_t);
      default: hold = long_t + $urandom_range(0, 2 * long_t + 10);
    endcase
    add_hold(1'b0, hold);
    repeat ($urandom_range(0, 2)) begin
      add_sample(1'b1, $urandom_range(0, deb_t / 2));
      add_sample(1'b0, $urandom_range(0, deb_t / 2));
    end
    add_sample(1'b1, $urandom_range(0, 5));
    add_hold(1'b1, near(deb_t));
    add_sample(1'b1, $urandom_range(0, 3));
  endtask

  task automatic add_random_items(int unsigned count);
    int unsigned base;
    base = n_queued;
    while (n_queued - base < count) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) != 0) push_sample(1'($urandom_range(0, 1)), $urandom);
        else add_sample(1'($urandom_range(0, 1)), $urandom_range(0, 2 * deb_t + 2));
      end else begin
        add_press();
      end
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_class_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [AddrW-1:0] addr, logic [ThreshW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(logic [AddrW-1:0] addr, logic [ThreshW-1:0] val, string name);
    logic [DataW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== DataW'(val)) begin
      $error("%s expected %0d actual %0d", name, val, got);
      err_cnt++;
    end
  endtask

  task automatic set_thresholds(int unsigned deb, int unsigned lng);
    apb_write(DebounceAddr, ThreshW'(deb));
    apb_write(LongPressAddr, ThreshW'(lng));
    apb_check(DebounceAddr, ThreshW'(deb), "debounce_ms");
    apb_check(LongPressAddr, ThreshW'(lng), "long_press_ms");
    deb_t  = deb;
    long_t = lng;
  endtask

  // Reset-value thresholds: bouncy presses, a bounce during release, a
  // timestamp wrap through a long press and a timestamp that runs backward.
  task automatic add_directed();
    push_sample(1'b1, 32'd0);
    push_sample(1'b0, 32'd5);
    push_sample(1'b1, 32'd8);
    push_sample(1'b0, 32'd20);
    push_sample(1'b0, 32'd29);
    push_sample(1'b0, 32'd30);
    push_sample(1'b1, 32'd100);
    push_sample(1'b0, 32'd105);
    push_sample(1'b1, 32'd200);
    push_sample(1'b1, 32'd209);
    push_sample(1'b1, 32'd210);
    push_sample(1'b0, 32'hFFFF_FF00);
    push_sample(1'b0, 32'hFFFF_FF0A);
    push_sample(1'b0, 32'h0000_0300);
    push_sample(1'b1, 32'h0000_0310);
    push_sample(1'b0, 32'h0000_0312);
    push_sample(1'b1, 32'h0000_0320);
    push_sample(1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'h0000_0000);
    push_sample(1'b0, 32'h7FFF_FFFF);
    push_sample(1'b1, 32'h8000_0000);
    push_sample(1'b1, 32'hAAAA_5555);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int unsigned p = 0; p < PhaseCount; p++) begin
      wait_drained();
      if (p != 0) set_thresholds(deb_set[p], long_set[p]);
      if (p < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 81;
      end else if (p < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) add_directed();
      add_random_items(PhaseItems / 2);
      // Let the pipeline empty completely before the second half.
      wait_drained();
      add_random_items(PhaseItems / 2);
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && expected_class_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== button_debounce_press_classifier.f =====
src/bdpc_pkg.sv
src/bdpc_fsm.sv
src/button_debounce_press_classifier.sv
sim/tb.sv
